>>> rtl/vertex_layout_calculator_unit_assert.svh
// assertion macros used by the vertex layout calculator rtl
`ifndef VERTEX_LAYOUT_CALCULATOR_UNIT_ASSERT_SVH
`define VERTEX_LAYOUT_CALCULATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define VLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define VLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vlc_pkg.sv
`timescale 1ns / 1ps

package vlc_pkg;

  localparam int unsigned MAX_STAGES_DEF = 8;
  localparam int unsigned UPC_W          = 4;

  // record kinds
  localparam logic [3:0] REC_POSITION = 4'd0;
  localparam logic [3:0] REC_WEIGHTS  = 4'd1;
  localparam logic [3:0] REC_PALETTE  = 4'd2;
  localparam logic [3:0] REC_NORMAL   = 4'd3;
  localparam logic [3:0] REC_COLOR    = 4'd4;
  localparam logic [3:0] REC_SPECULAR = 4'd5;
  localparam logic [3:0] REC_TEXCOORD = 4'd6;
  localparam logic [3:0] REC_TANGENT  = 4'd7;
  localparam logic [3:0] REC_BINORMAL = 4'd8;
  localparam logic [3:0] REC_SUMMARY  = 4'd9;

  // attribute flag bits
  localparam int unsigned FLG_NORMAL    = 0;
  localparam int unsigned FLG_DIFFUSE   = 1;
  localparam int unsigned FLG_SPECULAR  = 2;
  localparam int unsigned FLG_FDIFFUSE  = 3;
  localparam int unsigned FLG_FSPECULAR = 4;
  localparam int unsigned FLG_TANGENT   = 5;
  localparam int unsigned FLG_BINORMAL  = 6;
  localparam int unsigned FLG_PALETTE   = 7;

  // position kinds
  localparam logic [3:0] POS_XYZ       = 4'd1;
  localparam logic [3:0] POS_XYZRHW    = 4'd2;
  localparam logic [3:0] POS_XYZW      = 4'd3;
  localparam logic [3:0] POS_BLEND_LO  = 4'd4;
  localparam logic [3:0] POS_BLEND_HI  = 4'd8;

  typedef struct packed {
    logic [3:0]  position_kind;
    logic [7:0]  attribute_flags;
    logic [3:0]  stage_count;
    logic [23:0] stage_sizes;
  } desc_t;

  typedef struct packed {
    logic [3:0] record_kind;
    logic [2:0] stage_index;
    logic [5:0] offset_floats;
    logic [2:0] dimension;
    logic [7:0] total_bytes;
    logic [4:0] element_count;
    logic       last_record;
  } rec_t;

  typedef enum logic [3:0] {
    OP_POS,
    OP_WEIGHTS,
    OP_PALETTE,
    OP_NORMAL,
    OP_COLOR,
    OP_SPEC,
    OP_TEX,
    OP_TANGENT,
    OP_BINORMAL,
    OP_SUMMARY
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,        // fall through
    C_NO_STAGES,   // jump when no texture stages
    C_MORE_STAGES, // jump back while stages remain
    C_END          // program done
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  localparam logic [UPC_W-1:0] UPC_TEX     = UPC_W'(6);
  localparam logic [UPC_W-1:0] UPC_TANGENT = UPC_W'(7);

  // microprogram, one step per element slot
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{op: OP_POS,      cond: C_NEXT,        target: '0};
      4'd1:    w = '{op: OP_WEIGHTS,  cond: C_NEXT,        target: '0};
      4'd2:    w = '{op: OP_PALETTE,  cond: C_NEXT,        target: '0};
      4'd3:    w = '{op: OP_NORMAL,   cond: C_NEXT,        target: '0};
      4'd4:    w = '{op: OP_COLOR,    cond: C_NEXT,        target: '0};
      4'd5:    w = '{op: OP_SPEC,     cond: C_NO_STAGES,   target: UPC_TANGENT};
      4'd6:    w = '{op: OP_TEX,      cond: C_MORE_STAGES, target: UPC_TEX};
      4'd7:    w = '{op: OP_TANGENT,  cond: C_NEXT,        target: '0};
      4'd8:    w = '{op: OP_BINORMAL, cond: C_NEXT,        target: '0};
      4'd9:    w = '{op: OP_SUMMARY,  cond: C_END,         target: '0};
      default: w = '{op: OP_SUMMARY,  cond: C_END,         target: '0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/vlc_stream_if.sv
`timescale 1ns / 1ps

interface vlc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vertex_layout_calculator_unit.sv
`timescale 1ns / 1ps
// vertex layout calculator
// desc_i (sink, payload vlc_pkg::desc_t) takes one vertex format descriptor per
// request; rec_o (source, payload vlc_pkg::rec_t) returns one record per
// present element in fixed order, then a summary record with last_record set
// that carries the vertex size in bytes and the element count.
// a request is taken at a clock edge where valid and ready are both high.
// desc_i.ready is high whenever no descriptor is in progress, also while the
// summary of the previous descriptor still sits in the output register.
// a microprogram walks the element slots one step per cycle while the output
// slot is free or freeing; the texture step runs once per stage in use and is
// skipped when there are none. the first record is written to the output
// register by the first step after the accept edge, at the earliest.
// when rec_o.ready is low with a record pending, the step counter holds and
// the record stays in the output register until taken.
// rst_ni clears the sequencer and the output valid asynchronously; no request
// is in progress after reset.
`include "vertex_layout_calculator_unit_assert.svh"

module vertex_layout_calculator_unit #(
  parameter int unsigned MaxStages = vlc_pkg::MAX_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vlc_stream_if.sink        desc_i,
  vlc_stream_if.source      rec_o
);
  import vlc_pkg::*;

  // held descriptor
  logic [3:0]       pos_q;
  logic [7:0]       flags_q;
  logic [3:0]       cnt_q;
  logic [23:0]      sizes_q;

  // sequencer state
  logic             busy_q;
  logic [UPC_W-1:0] pc_q;
  logic [2:0]       s_q;
  logic [5:0]       off_q;
  logic [4:0]       elems_q;

  // output register
  logic             rec_valid_q;
  rec_t             rec_q;

  ucode_t           uc;
  logic             accept;
  logic             fire;
  logic [3:0]       cnt_sat;

  // datapath results for the current step
  logic             emit;
  logic [3:0]       kind;
  logic [5:0]       rec_off;
  logic [2:0]       dim;
  logic [3:0]       adv;
  logic [1:0]       inc;

  logic             blend;
  logic [2:0]       betas;
  logic [2:0]       raw_sz;
  logic [2:0]       tex_sz;
  logic             f_dif, f_spc, f_fdif, f_fspc;
  logic [3:0]       s_next;

  assign uc     = ucode_rom(pc_q);
  assign accept = desc_i.valid && desc_i.ready;
  // a step runs only when the output slot is free or freeing this cycle
  assign fire   = busy_q && (!rec_valid_q || rec_o.ready);

  assign cnt_sat = (desc_i.data.stage_count > 4'(MaxStages)) ? 4'(MaxStages)
                                                             : desc_i.data.stage_count;

  assign desc_i.ready = !busy_q;
  assign rec_o.valid  = rec_valid_q;
  assign rec_o.data   = rec_q;

  assign blend  = (pos_q >= POS_BLEND_LO) && (pos_q <= POS_BLEND_HI);
  assign betas  = 3'(pos_q - 4'd3);
  assign raw_sz = sizes_q[3*s_q +: 3];
  assign tex_sz = (raw_sz > 3'd4) ? 3'd4 : raw_sz;
  assign f_dif  = flags_q[FLG_DIFFUSE];
  assign f_spc  = flags_q[FLG_SPECULAR];
  assign f_fdif = flags_q[FLG_FDIFFUSE];
  assign f_fspc = flags_q[FLG_FSPECULAR];
  assign s_next = {1'b0, s_q} + 4'd1;

  // element datapath, selected by the step's opcode
  always_comb begin
    emit    = 1'b0;
    kind    = REC_SUMMARY;
    rec_off = off_q;
    dim     = 3'd0;
    adv     = 4'd0;
    inc     = 2'd0;
    case (uc.op)
      OP_POS: begin
        kind = REC_POSITION;
        emit = (pos_q >= POS_XYZ) && (pos_q <= POS_BLEND_HI);
        dim  = ((pos_q == POS_XYZRHW) || (pos_q == POS_XYZW)) ? 3'd4 : 3'd3;
      end
      OP_WEIGHTS: begin
        kind = REC_WEIGHTS;
        emit = blend && (!flags_q[FLG_PALETTE] || (betas > 3'd1));
        dim  = flags_q[FLG_PALETTE] ? (betas - 3'd1) : betas;
      end
      OP_PALETTE: begin
        kind = REC_PALETTE;
        emit = blend && flags_q[FLG_PALETTE];
        dim  = 3'd1;
      end
      OP_NORMAL: begin
        kind = REC_NORMAL;
        emit = flags_q[FLG_NORMAL];
        dim  = 3'd3;
      end
      OP_COLOR: begin
        // space for both color forms is taken by the specular step
        kind    = REC_COLOR;
        emit    = f_dif || f_fdif;
        rec_off = f_fdif ? (off_q + 6'(f_dif) + 6'(f_spc)) : off_q;
        dim     = f_fdif ? 3'd4 : 3'd1;
        inc     = 2'(f_dif) + 2'(f_fdif);
      end
      OP_SPEC: begin
        kind    = REC_SPECULAR;
        emit    = f_spc || f_fspc;
        rec_off = off_q + 6'(f_dif)
                + (f_fspc ? (6'(f_spc) + (f_fdif ? 6'd4 : 6'd0)) : 6'd0);
        dim     = f_fspc ? 3'd4 : 3'd1;
        // skip packed diffuse, packed specular and both float forms
        adv     = 4'(f_dif) + 4'(f_spc) + (f_fdif ? 4'd4 : 4'd0)
                + (f_fspc ? 4'd4 : 4'd0);
        inc     = 2'(f_spc) + 2'(f_fspc);
      end
      OP_TEX: begin
        kind = REC_TEXCOORD;
        emit = (tex_sz != 3'd0);
        dim  = tex_sz;
      end
      OP_TANGENT: begin
        kind = REC_TANGENT;
        emit = flags_q[FLG_TANGENT];
        dim  = flags_q[FLG_BINORMAL] ? 3'd3 : 3'd4;
      end
      OP_BINORMAL: begin
        kind = REC_BINORMAL;
        emit = flags_q[FLG_BINORMAL];
        dim  = 3'd3;
      end
      OP_SUMMARY: begin
        kind = REC_SUMMARY;
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // plain elements advance by their own size and count once
    if ((uc.op != OP_COLOR) && (uc.op != OP_SPEC) && (uc.op != OP_SUMMARY)) begin
      adv = emit ? {1'b0, dim} : 4'd0;
      inc = emit ? 2'd1 : 2'd0;
    end
  end

  // sequencer: step counter with conditional jumps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= '0;
      s_q     <= '0;
      off_q   <= '0;
      elems_q <= '0;
    end else if (accept) begin
      busy_q  <= 1'b1;
      pc_q    <= '0;
      s_q     <= '0;
      off_q   <= '0;
      elems_q <= '0;
    end else if (fire) begin
      off_q   <= off_q + 6'(adv);
      elems_q <= elems_q + 5'(inc);
      if (uc.op == OP_TEX) begin
        s_q <= s_q + 3'd1;
      end
      case (uc.cond)
        C_NEXT: begin
          pc_q <= pc_q + UPC_W'(1);
        end
        C_NO_STAGES: begin
          pc_q <= (cnt_q == 4'd0) ? uc.target : (pc_q + UPC_W'(1));
        end
        C_MORE_STAGES: begin
          pc_q <= (s_next < cnt_q) ? uc.target : (pc_q + UPC_W'(1));
        end
        C_END: begin
          busy_q <= 1'b0;
          pc_q   <= '0;
        end
        default: begin
          busy_q <= 1'b0;
        end
      endcase
    end
  end

  // descriptor hold register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q   <= desc_i.data.position_kind;
      flags_q <= desc_i.data.attribute_flags;
      cnt_q   <= cnt_sat;
      sizes_q <= desc_i.data.stage_sizes;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else if (fire && emit) begin
      rec_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      rec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      rec_q.record_kind <= kind;
      if (uc.op == OP_SUMMARY) begin
        rec_q.stage_index   <= 3'd0;
        rec_q.offset_floats <= 6'd0;
        rec_q.dimension     <= 3'd0;
        rec_q.total_bytes   <= {off_q, 2'b00};
        rec_q.element_count <= elems_q;
        rec_q.last_record   <= 1'b1;
      end else begin
        rec_q.stage_index   <= (uc.op == OP_TEX) ? s_q : 3'd0;
        rec_q.offset_floats <= rec_off;
        rec_q.dimension     <= dim;
        rec_q.total_bytes   <= 8'd0;
        rec_q.element_count <= 5'd0;
        rec_q.last_record   <= 1'b0;
      end
    end
  end

  // checks
  `VLC_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, accept,
                  busy_q && (pc_q == '0) && (s_q == 3'd0),
                  "descriptor accept did not restart the microprogram")
  `VLC_ASSERT_IMP(a_tex_in_range, clk_i, rst_ni, busy_q && (uc.op == OP_TEX),
                  (4'(s_q) < cnt_q),
                  "texture step running past the stage count")
  `VLC_ASSERT_IMP(a_last_is_summary, clk_i, rst_ni,
                  rec_valid_q && rec_q.last_record,
                  (rec_q.record_kind == REC_SUMMARY) && (rec_q.offset_floats == 6'd0)
                  && (rec_q.dimension == 3'd0),
                  "last record is not a clean summary")
  `VLC_ASSERT_IMP(a_no_step_when_full, clk_i, rst_ni,
                  busy_q && rec_valid_q && !rec_o.ready, !fire,
                  "sequencer advanced over a pending record")

endmodule

>>> tb/sv/tb_vertex_layout_calculator_unit.sv
`timescale 1ns / 1ps

module tb_vertex_layout_calculator_unit;
  import vlc_pkg::*;

  // attribute flag masks built from the package bit positions
  localparam logic [7:0] M_NORMAL    = 8'(1) << FLG_NORMAL;
  localparam logic [7:0] M_DIFFUSE   = 8'(1) << FLG_DIFFUSE;
  localparam logic [7:0] M_SPECULAR  = 8'(1) << FLG_SPECULAR;
  localparam logic [7:0] M_FDIFFUSE  = 8'(1) << FLG_FDIFFUSE;
  localparam logic [7:0] M_FSPECULAR = 8'(1) << FLG_FSPECULAR;
  localparam logic [7:0] M_TANGENT   = 8'(1) << FLG_TANGENT;
  localparam logic [7:0] M_BINORMAL  = 8'(1) << FLG_BINORMAL;
  localparam logic [7:0] M_PALETTE   = 8'(1) << FLG_PALETTE;

  localparam logic [3:0] POS_NONE = 4'd0;

  // traffic phases: sender idles lightly, then receiver idles lightly, then no idling
  localparam int PH_RECV_SLOW = 0;
  localparam int PH_SEND_SLOW = 1;
  localparam int PH_FULL_RATE = 2;

  // receiver hold-off window, counted in cycles of the full-rate phase
  localparam int HOLD_START = 20;
  localparam int HOLD_END   = 220;

  logic clk_i = 1'b0;
  logic rst_ni;

  vlc_stream_if #(.payload_t(desc_t)) desc_if ();
  vlc_stream_if #(.payload_t(rec_t))  rec_if ();

  vertex_layout_calculator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .desc_i (desc_if),
    .rec_o  (rec_if)
  );

  always #5 clk_i = ~clk_i;

  desc_t       desc_backlog[$];   // descriptors waiting to be offered
  rec_t        layout_records[$]; // records the block still owes us
  rec_t        next_rec;
  int          phase;
  int          mismatches;
  int          full_rate_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  assign send_idle_pct = (phase == PH_RECV_SLOW) ? 6 : (phase == PH_SEND_SLOW) ? 55 : 0;
  assign recv_idle_pct = (phase == PH_RECV_SLOW) ? 55 : (phase == PH_SEND_SLOW) ? 6 : 0;

  function automatic void queue_element(input logic [3:0] kind, input int stage,
                                        input int ofs, input int dim);
    rec_t r;
    r               = '0;
    r.record_kind   = kind;
    r.stage_index   = 3'(stage);
    r.offset_floats = 6'(ofs);
    r.dimension     = 3'(dim);
    layout_records.push_back(r);
  endfunction

  // work out the full record stream of one descriptor
  function automatic void predict_layout(input desc_t d);
    int   ofs;
    int   elems;
    int   blends;
    int   nstages;
    int   sz;
    int   col_ofs;
    int   col_dim;
    int   spc_ofs;
    int   spc_dim;
    rec_t summ;
    ofs     = 0;
    elems   = 0;
    col_ofs = 0;
    col_dim = 0;
    spc_ofs = 0;
    spc_dim = 0;

    // position, with blend betas following xyz at word 3
    if (d.position_kind == POS_XYZ) begin
      queue_element(REC_POSITION, 0, 0, 3);
      ofs   = 3;
      elems = 1;
    end else if (d.position_kind == POS_XYZRHW || d.position_kind == POS_XYZW) begin
      queue_element(REC_POSITION, 0, 0, 4);
      ofs   = 4;
      elems = 1;
    end else if (d.position_kind >= POS_BLEND_LO && d.position_kind <= POS_BLEND_HI) begin
      blends = int'(d.position_kind) - int'(POS_XYZW);
      queue_element(REC_POSITION, 0, 0, 3);
      elems = 1;
      if (d.attribute_flags[FLG_PALETTE]) begin
        // last beta is the palette index, the rest are weights
        if (blends > 1) begin
          queue_element(REC_WEIGHTS, 0, 3, blends - 1);
          elems++;
        end
        queue_element(REC_PALETTE, 0, 2 + blends, 1);
        elems++;
      end else begin
        queue_element(REC_WEIGHTS, 0, 3, blends);
        elems++;
      end
      ofs = 3 + blends;
    end
    // unused position kinds fall through with no position at all

    if (d.attribute_flags[FLG_NORMAL]) begin
      queue_element(REC_NORMAL, 0, ofs, 3);
      ofs += 3;
      elems++;
    end

    // both color forms take space, the float form wins the single record
    if (d.attribute_flags[FLG_DIFFUSE]) begin
      col_ofs = ofs; col_dim = 1; ofs += 1; elems++;
    end
    if (d.attribute_flags[FLG_SPECULAR]) begin
      spc_ofs = ofs; spc_dim = 1; ofs += 1; elems++;
    end
    if (d.attribute_flags[FLG_FDIFFUSE]) begin
      col_ofs = ofs; col_dim = 4; ofs += 4; elems++;
    end
    if (d.attribute_flags[FLG_FSPECULAR]) begin
      spc_ofs = ofs; spc_dim = 4; ofs += 4; elems++;
    end
    if (col_dim != 0) queue_element(REC_COLOR, 0, col_ofs, col_dim);
    if (spc_dim != 0) queue_element(REC_SPECULAR, 0, spc_ofs, spc_dim);

    // texture stages, count and sizes both saturate, empty stages vanish
    nstages = (d.stage_count > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(d.stage_count);
    for (int s = 0; s < nstages; s++) begin
      sz = int'(d.stage_sizes[3*s +: 3]);
      if (sz > 4) sz = 4;
      if (sz > 0) begin
        queue_element(REC_TEXCOORD, s, ofs, sz);
        ofs += sz;
        elems++;
      end
    end

    if (d.attribute_flags[FLG_TANGENT]) begin
      sz = d.attribute_flags[FLG_BINORMAL] ? 3 : 4;
      queue_element(REC_TANGENT, 0, ofs, sz);
      ofs += sz;
      elems++;
    end
    if (d.attribute_flags[FLG_BINORMAL]) begin
      queue_element(REC_BINORMAL, 0, ofs, 3);
      ofs += 3;
      elems++;
    end

    summ               = '0;
    summ.record_kind   = REC_SUMMARY;
    summ.total_bytes   = 8'(ofs * 4);
    summ.element_count = 5'(elems);
    summ.last_record   = 1'b1;
    layout_records.push_back(summ);
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: record %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_desc(input logic [3:0] pos, input logic [7:0] flags,
                                   input logic [3:0] cnt, input logic [23:0] sizes);
    desc_t d;
    d.position_kind   = pos;
    d.attribute_flags = flags;
    d.stage_count     = cnt;
    d.stage_sizes     = sizes;
    desc_backlog.push_back(d);
  endfunction

  // mostly legal descriptors, with some unused position kinds and oversized counts
  function automatic desc_t random_desc();
    desc_t d;
    if ($urandom_range(9) == 0) d.position_kind = 4'($urandom_range(15, 9));
    else d.position_kind = 4'($urandom_range(8));
    d.attribute_flags = 8'($urandom);
    if ($urandom_range(9) == 0) d.stage_count = 4'($urandom_range(15, 9));
    else d.stage_count = 4'($urandom_range(8));
    if ($urandom_range(2) == 0) begin
      d.stage_sizes = 24'($urandom);
    end else begin
      for (int i = 0; i < 8; i++) d.stage_sizes[3*i +: 3] = 3'($urandom_range(4));
    end
    return d;
  endfunction

  task automatic wait_drained();
    while (desc_backlog.size() != 0 || layout_records.size() != 0 || desc_if.valid)
      @(negedge clk_i);
  endtask

  // request driver: hold an offered descriptor until taken, else pull the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_if.valid <= 1'b0;
      desc_if.data  <= '0;
    end else begin
      if (desc_if.valid && desc_if.ready) predict_layout(desc_if.data);
      if (desc_if.valid && !desc_if.ready) begin
        // stalled, keep offering the same descriptor
      end else if (desc_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        desc_if.valid <= 1'b1;
        desc_if.data  <= desc_backlog.pop_front();
      end else begin
        desc_if.valid <= 1'b0;
      end
    end
  end

  // record monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_if.ready     <= 1'b0;
      mismatches       <= 0;
      full_rate_cycles <= 0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        if (layout_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, got kind %0d", $time,
                   rec_if.data.record_kind);
          mismatches++;
        end else begin
          next_rec = layout_records.pop_front();
          check_field("record_kind", 8'(next_rec.record_kind), 8'(rec_if.data.record_kind));
          check_field("stage_index", 8'(next_rec.stage_index), 8'(rec_if.data.stage_index));
          check_field("offset_floats", 8'(next_rec.offset_floats),
                      8'(rec_if.data.offset_floats));
          check_field("dimension", 8'(next_rec.dimension), 8'(rec_if.data.dimension));
          check_field("total_bytes", next_rec.total_bytes, rec_if.data.total_bytes);
          check_field("element_count", 8'(next_rec.element_count),
                      8'(rec_if.data.element_count));
          check_field("last_record", 8'(next_rec.last_record), 8'(rec_if.data.last_record));
        end
      end

      // one long hold-off early in the full-rate phase fills the block and stalls its input
      if (phase == PH_FULL_RATE && full_rate_cycles < HOLD_END)
        full_rate_cycles <= full_rate_cycles + 1;
      if (phase == PH_FULL_RATE && full_rate_cycles >= HOLD_START &&
          full_rate_cycles < HOLD_END)
        rec_if.ready <= 1'b0;
      else
        rec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    phase  = PH_RECV_SLOW;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners
    add_desc(POS_NONE, 8'h00, 4'd0, 24'h000000);
    add_desc(POS_XYZ, 8'h00, 4'd0, 24'h000000);
    add_desc(POS_XYZRHW, M_NORMAL, 4'd1, 24'o00000002);
    add_desc(POS_XYZW, M_DIFFUSE, 4'd0, 24'h000000);
    add_desc(POS_BLEND_LO, 8'h00, 4'd0, 24'h000000);
    add_desc(POS_BLEND_LO, M_PALETTE, 4'd0, 24'h000000);
    add_desc(POS_BLEND_LO + 4'd1, M_PALETTE, 4'd0, 24'h000000);
    add_desc(POS_BLEND_HI, 8'h00, 4'd0, 24'h000000);
    // every element present, with all stages at their largest
    add_desc(POS_BLEND_HI, 8'hFF, 4'd8, 24'hFFFFFF);
    add_desc(4'd15, M_DIFFUSE | M_FDIFFUSE, 4'd2, 24'o00000030);
    add_desc(4'd9, M_SPECULAR | M_FSPECULAR, 4'd1, 24'o00000001);
    add_desc(POS_XYZ, M_FDIFFUSE, 4'd0, 24'h000000);
    add_desc(POS_XYZ, M_FSPECULAR, 4'd0, 24'h000000);
    add_desc(POS_XYZ, M_SPECULAR, 4'd0, 24'h000000);
    add_desc(POS_XYZ, M_TANGENT, 4'd0, 24'h000000);
    add_desc(POS_XYZ, M_BINORMAL, 4'd0, 24'h000000);
    add_desc(POS_XYZ, M_TANGENT | M_BINORMAL, 4'd0, 24'h000000);
    // stage count above the maximum
    add_desc(POS_NONE, 8'h00, 4'd15, 24'o44444444);
    // empty stage, and sizes above four
    add_desc(POS_NONE, 8'h00, 4'd8, 24'o76543210);
    add_desc(POS_NONE, 8'h00, 4'd0, 24'hFFFFFF);
    add_desc(POS_XYZRHW, M_NORMAL, 4'd3, 24'o00000111);
    add_desc(POS_XYZW, 8'h7F, 4'd12, 24'h000000);
    add_desc(POS_BLEND_HI - 4'd1, M_PALETTE | M_TANGENT | M_SPECULAR | M_NORMAL, 4'd4,
             24'o00003210);

    for (int i = 0; i < 75; i++) desc_backlog.push_back(random_desc());
    wait_drained();

    phase = PH_SEND_SLOW;
    for (int i = 0; i < 80; i++) desc_backlog.push_back(random_desc());
    wait_drained();

    phase = PH_FULL_RATE;
    for (int i = 0; i < 80; i++) desc_backlog.push_back(random_desc());
    wait_drained();

    // let anything stray show up
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && layout_records.size() == 0) begin
      $display("tb_vertex_layout_calculator_unit: PASS");
    end else begin
      $display("tb_vertex_layout_calculator_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_vertex_layout_calculator_unit: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/vlc_pkg.sv
rtl/vlc_stream_if.sv
rtl/vertex_layout_calculator_unit.sv
tb/sv/tb_vertex_layout_calculator_unit.sv
